/* hdl/hdbn_pkg.sv */
// ----------------------------------------------------------------------------
// HDBn encoder package
// Shared types and constants of the HDBn line encoder and its delay cells.
// ----------------------------------------------------------------------------
`default_nettype none

package hdbn_pkg;

   // Configuration register width and reset value (HDB3).
   localparam int CFG_W = 3;
   localparam logic [CFG_W-1:0] ZERO_LIMIT_RESET = 3'd3;

   // Default longest delay the line is built for.
   localparam int MAX_RUN_DEFAULT = 7;

   // Ternary line symbols.
   typedef logic signed [1:0] symbol_type;
   localparam symbol_type SYM_ZERO = 2'sb00;
   localparam symbol_type SYM_POS  = 2'sb01;
   localparam symbol_type SYM_NEG  = 2'sb11;

   // Input actions.
   localparam logic ACTION_PUSH  = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   typedef struct packed {
      logic action;
      logic data_bit;
   } req_item_type;

   typedef struct packed {
      symbol_type symbol;
      logic       valid_res;
      logic       last;
   } rsp_item_type;

   // Controls broadcast to every cell of the delay line.
   typedef struct packed {
      logic       shift;
      logic       clear;
      symbol_type wr_sym;
      symbol_type bal_sym;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* hdl/hdbn_cell.sv */
// ----------------------------------------------------------------------------
// HDBn delay cell
// One symbol slot of the delay line: takes a new or balancing symbol and
// shifts toward the output end.
// ----------------------------------------------------------------------------
`default_nettype none

module hdbn_cell
   import hdbn_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire logic         wr_sel,
   input  wire logic         bal_sel,
   input  wire symbol_type   upper_sym,
   output      symbol_type   post_sym
);

   symbol_type sym_ff;
   symbol_type sym_in;

   // The value after this beat's writes is what the lower neighbor shifts in.
   always_comb begin
      if (bal_sel) begin
         post_sym = ctl.bal_sym;
      end else if (wr_sel) begin
         post_sym = ctl.wr_sym;
      end else begin
         post_sym = sym_ff;
      end
   end

   always_comb begin
      if (ctl.clear) begin
         sym_in = SYM_ZERO;
      end else if (ctl.shift) begin
         sym_in = upper_sym;
      end else begin
         sym_in = post_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= SYM_ZERO;
      end else begin
         sym_ff <= sym_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/hdbn_line_encoder_top.sv */
// A result beat is registered and appears on rsp in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; a request is taken in the cycle the previous result
// leaves, and a stalled result holds off the request side.
// The line symbol in a result lags its data bit by n beats (n = zero limit).
// Reset (synchronous, active high) empties the delay line, clears the coder
// state and sets the zero limit to 3 (HDB3).
// ----------------------------------------------------------------------------
// HDBn line encoder
// Alternate mark inversion with n+1 zero substitution through a chain of
// delay cells, plus frame drain.
// ----------------------------------------------------------------------------
`default_nettype none

module hdbn_line_encoder_top
   import hdbn_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEFAULT
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_item_type     req_item,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      rsp_item_type     rsp_item,
   input  wire logic             csr_write_enable,
   input  wire logic [CFG_W-1:0] csr_write_data
);

   localparam int DEPTH = MAX_RUN + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CW    = IDX_W + 4;

   logic [CFG_W-1:0] zero_limit_ff;
   logic [IDX_W-1:0] held_ff, held_in;
   logic [IDX_W-1:0] run_ff, run_in;
   logic             mark_neg_ff, mark_neg_in;
   logic             viol_pos_ff, viol_pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             accept;
   logic             is_drain;
   logic [CW-1:0]    limit_cw, ne_cw, held_cw, run_next_cw, bal_idx_cw;
   logic             viol;
   logic             bal_en;
   logic             pop;
   logic             clear_cond;
   symbol_type       push_sym, viol_sym;
   cell_ctl_type     cell_ctl;
   logic [DEPTH-1:0] wr_sel, bal_sel;
   symbol_type       sym_post [0:DEPTH];

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign is_drain  = (req_item.action == ACTION_DRAIN);

   // Effective limit, kept between 1 and MAX_RUN.
   always_comb begin
      limit_cw = CW'(zero_limit_ff);
      if (limit_cw == '0) begin
         ne_cw = CW'(1);
      end else if (limit_cw > CW'(MAX_RUN)) begin
         ne_cw = CW'(MAX_RUN);
      end else begin
         ne_cw = limit_cw;
      end
   end

   always_comb begin
      held_cw     = CW'(held_ff);
      run_next_cw = CW'(run_ff) + CW'(1);
      bal_idx_cw  = held_cw - ne_cw;
      viol_sym    = viol_pos_ff ? SYM_NEG : SYM_POS;
      viol        = !req_item.data_bit && (run_next_cw >= ne_cw + CW'(1));
      // The balancing pulse replaces the run's first zero, which must still be held.
      bal_en      = viol && (mark_neg_ff == !viol_pos_ff) && (held_cw >= ne_cw);
      pop         = (held_cw + CW'(1)) > ne_cw;
      clear_cond  = (held_ff == '0) || (held_ff == IDX_W'(1));
      if (req_item.data_bit) begin
         push_sym = mark_neg_ff ? SYM_POS : SYM_NEG;
      end else if (viol) begin
         push_sym = viol_sym;
      end else begin
         push_sym = SYM_ZERO;
      end
   end

   always_comb begin
      cell_ctl.wr_sym  = push_sym;
      cell_ctl.bal_sym = viol_sym;
      cell_ctl.shift   = accept && (is_drain ? (held_ff != '0) : pop);
      cell_ctl.clear   = accept && is_drain && clear_cond;
      for (int k = 0; k < DEPTH; k++) begin
         wr_sel[k]  = accept && !is_drain && (held_ff == IDX_W'(k));
         bal_sel[k] = accept && !is_drain && bal_en && (bal_idx_cw[IDX_W-1:0] == IDX_W'(k));
      end
   end

   assign sym_post[DEPTH] = SYM_ZERO;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      hdbn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .wr_sel    (wr_sel[k]),
         .bal_sel   (bal_sel[k]),
         .upper_sym (sym_post[k+1]),
         .post_sym  (sym_post[k])
      );
   end

   // Coder state and result beat.
   always_comb begin
      held_in     = held_ff;
      run_in      = run_ff;
      mark_neg_in = mark_neg_ff;
      viol_pos_in = viol_pos_ff;
      rsp_item_in = rsp_item_ff;
      if (accept) begin
         rsp_item_in.symbol    = SYM_ZERO;
         rsp_item_in.valid_res = 1'b0;
         rsp_item_in.last      = 1'b0;
         if (is_drain) begin
            if (held_ff != '0) begin
               rsp_item_in.symbol    = sym_post[0];
               rsp_item_in.valid_res = 1'b1;
               rsp_item_in.last      = (held_ff == IDX_W'(1));
               held_in               = held_ff - IDX_W'(1);
            end
            if (clear_cond) begin
               held_in     = '0;
               run_in      = '0;
               mark_neg_in = 1'b1;
               viol_pos_in = 1'b0;
            end
         end else begin
            if (req_item.data_bit) begin
               run_in      = '0;
               mark_neg_in = !mark_neg_ff;
            end else if (viol) begin
               run_in      = '0;
               viol_pos_in = !viol_pos_ff;
               if (bal_en) begin
                  mark_neg_in = viol_pos_ff;
               end
            end else begin
               run_in = run_next_cw[IDX_W-1:0];
            end
            if (pop) begin
               rsp_item_in.symbol    = sym_post[0];
               rsp_item_in.valid_res = 1'b1;
            end else begin
               held_in = held_ff + IDX_W'(1);
            end
         end
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_limit_ff <= ZERO_LIMIT_RESET;
         held_ff       <= '0;
         run_ff        <= '0;
         mark_neg_ff   <= 1'b1;
         viol_pos_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            zero_limit_ff <= csr_write_data;
         end
         held_ff      <= held_in;
         run_ff       <= run_in;
         mark_neg_ff  <= mark_neg_in;
         viol_pos_ff  <= viol_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // A drain of the final held symbol flags the frame end and empties the line.
   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      accept && is_drain && (held_ff == IDX_W'(1))
      |=> (held_ff == '0) && rsp_valid && rsp_item.last)
      else $error("final drain did not close the frame");

   a_last_is_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> rsp_item.valid_res)
      else $error("frame end flagged on a fill beat");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !is_drain && !pop |=> held_ff == $past(held_ff) + IDX_W'(1))
      else $error("fill count did not advance");

endmodule

`default_nettype wire
